@@ hdl/midi_mpe_controller_router_unit_assert.svh @@
// assertion macros for the mpe controller router
`ifndef MIDI_MPE_CONTROLLER_ROUTER_UNIT_ASSERT_SVH
`define MIDI_MPE_CONTROLLER_ROUTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define MMCR_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MMCR_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MMCR_ASSERT(lbl, prop, msg)
`define MMCR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

@@ hdl/mmcr_pkg.sv @@
// types, constants and helpers shared by the mpe controller router
package mmcr_pkg;

    localparam int NUM_CHANNELS = 16;
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    typedef enum logic [1:0] {
        OP_CC       = 2'd0,
        OP_PRESSURE = 2'd1,
        OP_WHEEL    = 2'd2,
        OP_NOTE     = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        KIND_CC       = 3'd0,
        KIND_PRESSURE = 3'd1,
        KIND_WHEEL    = 3'd2,
        KIND_BEND     = 3'd3,
        KIND_NOTE     = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        UPD_NONE,
        UPD_MOD,
        UPD_TIMBRE,
        UPD_PRESSURE,
        UPD_RPN_HI,
        UPD_RPN_LO,
        UPD_SEMIS,
        UPD_CENTS
    } upd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_PRIMARY,
        ST_MAIN,
        ST_FAN
    } seq_state_t;

    localparam logic [2:0] CFG_ZONE_ENABLED   = 3'd0;
    localparam logic [2:0] CFG_MASTER_CHANNEL = 3'd1;
    localparam logic [2:0] CFG_FIRST_MEMBER   = 3'd2;
    localparam logic [2:0] CFG_LAST_MEMBER    = 3'd3;

    localparam logic [6:0] CC_MOD_WHEEL = 7'd1;
    localparam logic [6:0] CC_DATA_MSB  = 7'd6;
    localparam logic [6:0] CC_DATA_LSB  = 7'd38;
    localparam logic [6:0] CC_TIMBRE    = 7'd74;
    localparam logic [6:0] CC_RPN_LSB   = 7'd100;
    localparam logic [6:0] CC_RPN_MSB   = 7'd101;

    localparam logic [6:0] RPN_BEND_LSB   = 7'd0;
    localparam logic [6:0] RPN_LEGACY_LSB = 7'd6;
    localparam logic [6:0] RPN_MSB_ZERO   = 7'd0;
    localparam logic [6:0] RPN_NULL       = 7'd127;

    localparam logic [6:0] LEVEL_MAX     = 7'd127;
    localparam logic [6:0] SEMITONES_MAX = 7'd96;
    localparam logic [6:0] CENTS_MAX     = 7'd99;
    localparam logic [13:0] CENTS_PER_SEMITONE = 14'd100;

    typedef struct packed {
        op_t         op;
        logic [4:0]  channel;
        logic [6:0]  number;
        logic [13:0] value;
    } event_item_t;

    typedef struct packed {
        kind_t       kind;
        logic [4:0]  out_channel;
        logic [6:0]  out_number;
        logic [13:0] out_value;
        logic        mod_wheel_valid;
        logic [6:0]  mod_wheel_level;
        logic [6:0]  pressure_level;
        logic [6:0]  timbre_level;
        logic        bend_range_valid;
        logic [13:0] bend_range_hundredths;
        logic        last;
    } result_item_t;

    typedef struct packed {
        logic        on;
        logic [4:0]  master;
        logic [4:0]  first;
        logic [4:0]  last;
    } zone_t;

    typedef struct packed {
        logic        we;
        logic [4:0]  mgr;
        logic [13:0] count;
    } legacy_req_t;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] idx;
        upd_t             cmd;
        logic [6:0]       v7;
        logic [13:0]      val;
    } chan_req_t;

    typedef struct packed {
        logic        mod_valid;
        logic [6:0]  mod_level;
        logic [6:0]  pressure;
        logic [6:0]  timbre;
        logic        range_valid;
        logic [13:0] range;
    } snap_t;

    typedef struct packed {
        logic legacy_sel;
        logic bend_sel;
        logic range_upd;
    } chan_stat_t;

    typedef struct packed {
        logic        mod_valid;
        logic [6:0]  mod_level;
        logic [6:0]  pressure;
        logic [6:0]  timbre;
        logic [6:0]  rpn_hi;
        logic [6:0]  rpn_lo;
        logic        semis_valid;
        logic [6:0]  semis;
        logic [6:0]  cents;
        logic        range_valid;
        logic [13:0] range;
    } chan_entry_t;

    localparam chan_entry_t CHAN_RESET = '{
        mod_valid:   1'b0,
        mod_level:   7'd0,
        pressure:    7'd0,
        timbre:      7'd0,
        rpn_hi:      RPN_NULL,
        rpn_lo:      RPN_NULL,
        semis_valid: 1'b0,
        semis:       7'd0,
        cents:       7'd0,
        range_valid: 1'b0,
        range:       14'd0
    };

    function automatic logic [4:0] clamp16(input logic [4:0] c);
        logic [4:0] r;
        r = c;
        if (c == 5'd0)
        begin
            r = 5'd1;
        end
        else if (c > 5'd16)
        begin
            r = 5'd16;
        end
        return r;
    endfunction

    function automatic logic [IDX_W-1:0] slot(input logic [4:0] ch);
        logic [4:0] c;
        c = (ch > 5'(NUM_CHANNELS)) ? 5'(NUM_CHANNELS) : ch;
        if (c == 5'd0)
        begin
            c = 5'd1;
        end
        return IDX_W'(c - 5'd1);
    endfunction

endpackage

@@ hdl/mmcr_zone.sv @@
// zone registers: configuration load with validation and legacy retarget
module mmcr_zone
    import mmcr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data,
    input  legacy_req_t legacy,
    output zone_t       zone
);

    logic       cfg_en_reg, cfg_en_next;
    logic [4:0] cfg_master_reg, cfg_master_next;
    logic [4:0] cfg_first_reg, cfg_first_next;
    logic [4:0] cfg_last_reg, cfg_last_next;
    zone_t      zone_reg, zone_next;

    logic [4:0] m_c, f_c, l_c, f_s, l_s;
    zone_t      loaded;

    always_comb
    begin
        cfg_en_next     = cfg_en_reg;
        cfg_master_next = cfg_master_reg;
        cfg_first_next  = cfg_first_reg;
        cfg_last_next   = cfg_last_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ZONE_ENABLED:   cfg_en_next     = cfg_data[0];
                CFG_MASTER_CHANNEL: cfg_master_next = cfg_data;
                CFG_FIRST_MEMBER:   cfg_first_next  = cfg_data;
                CFG_LAST_MEMBER:    cfg_last_next   = cfg_data;
                default:            ;
            endcase
        end
    end

    // validation of the freshly written register set
    always_comb
    begin
        m_c = clamp16(cfg_master_next);
        f_c = clamp16(cfg_first_next);
        l_c = clamp16(cfg_last_next);
        f_s = (f_c > l_c) ? l_c : f_c;
        l_s = (f_c > l_c) ? f_c : l_c;
        if (cfg_en_next && m_c >= f_s && m_c <= l_s)
        begin
            loaded = '{on: 1'b0, master: 5'd1, first: 5'd2, last: 5'd16};
        end
        else
        begin
            loaded = '{on: cfg_en_next, master: m_c, first: f_s, last: l_s};
        end
    end

    always_comb
    begin
        zone_next = zone_reg;
        priority if (cfg_we && cfg_index <= CFG_LAST_MEMBER)
        begin
            zone_next = loaded;
        end
        else if (legacy.we && (legacy.mgr == 5'd1 || legacy.mgr == 5'd16)
                 && legacy.count <= 14'd15)
        begin
            if (legacy.count == 14'd0)
            begin
                if (zone_reg.on && zone_reg.master == legacy.mgr)
                begin
                    zone_next.on = 1'b0;
                end
            end
            else if (legacy.mgr == 5'd1)
            begin
                zone_next = '{on: 1'b1, master: 5'd1, first: 5'd2,
                              last: 5'(5'd1 + legacy.count[4:0])};
            end
            else
            begin
                zone_next = '{on: 1'b1, master: 5'd16,
                              first: 5'(5'd16 - legacy.count[4:0]), last: 5'd15};
            end
        end
        else
        begin
            zone_next = zone_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_en_reg     <= 1'b0;
            cfg_master_reg <= 5'd1;
            cfg_first_reg  <= 5'd2;
            cfg_last_reg   <= 5'd16;
            zone_reg       <= '{on: 1'b0, master: 5'd1, first: 5'd2, last: 5'd16};
        end
        else
        begin
            cfg_en_reg     <= cfg_en_next;
            cfg_master_reg <= cfg_master_next;
            cfg_first_reg  <= cfg_first_next;
            cfg_last_reg   <= cfg_last_next;
            zone_reg       <= zone_next;
        end
    end

    assign zone = zone_reg;

endmodule

@@ hdl/mmcr_chan_unit.sv @@
// per-channel state with one shared read-modify-write port
module mmcr_chan_unit
    import mmcr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  chan_req_t  req,
    output snap_t      snap,
    output chan_stat_t stat
);

    chan_entry_t ent_reg [NUM_CHANNELS];
    chan_entry_t cur, nxt;
    logic        range_upd;

    assign cur = ent_reg[req.idx];

    always_comb
    begin
        nxt = cur;
        range_upd = 1'b0;
        unique case (req.cmd)
            UPD_NONE:     ;
            UPD_MOD:
            begin
                nxt.mod_level = req.v7;
                nxt.mod_valid = 1'b1;
            end
            UPD_TIMBRE:   nxt.timbre = req.v7;
            UPD_PRESSURE: nxt.pressure = req.v7;
            UPD_RPN_HI:   nxt.rpn_hi = req.v7;
            UPD_RPN_LO:   nxt.rpn_lo = req.v7;
            UPD_SEMIS:
            begin
                nxt.semis = (req.val > 14'(SEMITONES_MAX)) ? SEMITONES_MAX : req.val[6:0];
                nxt.semis_valid = 1'b1;
            end
            UPD_CENTS:
            begin
                nxt.cents = (req.val > 14'(CENTS_MAX)) ? CENTS_MAX : req.val[6:0];
            end
            default:      ;
        endcase
        if ((req.cmd == UPD_SEMIS || req.cmd == UPD_CENTS) && nxt.semis_valid)
        begin
            nxt.range = 14'(14'(nxt.semis) * CENTS_PER_SEMITONE + 14'(nxt.cents));
            nxt.range_valid = 1'b1;
            range_upd = 1'b1;
        end
    end

    assign stat = '{
        legacy_sel: (cur.rpn_hi == RPN_MSB_ZERO) && (cur.rpn_lo == RPN_LEGACY_LSB),
        bend_sel:   (cur.rpn_hi == RPN_MSB_ZERO) && (cur.rpn_lo == RPN_BEND_LSB),
        range_upd:  range_upd
    };

    assign snap = '{
        mod_valid:   nxt.mod_valid,
        mod_level:   nxt.mod_level,
        pressure:    nxt.pressure,
        timbre:      nxt.timbre,
        range_valid: nxt.range_valid,
        range:       nxt.range
    };

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_CHANNELS; k++)
            begin
                ent_reg[k] <= CHAN_RESET;
            end
        end
        else if (req.we)
        begin
            ent_reg[req.idx] <= nxt;
        end
    end

endmodule

@@ hdl/mmcr_seq.sv @@
// event sequencer: decode, fan-out walk and result register
`include "midi_mpe_controller_router_unit_assert.svh"

module mmcr_seq
    import mmcr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         event_valid,
    output logic         event_stall,
    input  event_item_t  event_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item,
    input  zone_t        zone,
    output legacy_req_t  legacy,
    output chan_req_t    chan_req,
    input  snap_t        snap,
    input  chan_stat_t   stat
);

    seq_state_t   state_reg, state_next;
    op_t          op_reg, op_next;
    logic [4:0]   ch_reg, ch_next;
    logic [6:0]   num_reg, num_next;
    logic [13:0]  val_reg, val_next;
    logic [6:0]   v7_reg, v7_next;
    logic [4:0]   m_reg, m_next;
    logic         out_valid_reg, out_valid_next;
    result_item_t out_reg, out_next;

    logic         adv, accept, fan_op, fan_go, fan_last, legacy_hit, emit;
    upd_t         primary_cmd, member_cmd;
    kind_t        op_kind;
    result_item_t item;

    assign adv      = !out_valid_reg || !result_stall;
    assign accept   = event_valid && !event_stall;
    assign fan_op   = (op_reg == OP_CC && (num_reg == CC_MOD_WHEEL || num_reg == CC_TIMBRE))
                      || op_reg == OP_PRESSURE || op_reg == OP_WHEEL;
    assign fan_go   = fan_op && zone.on && ch_reg == zone.master
                      && zone.first <= zone.last && zone.first <= 5'(NUM_CHANNELS);
    assign fan_last = (m_reg == zone.last) || (m_reg == 5'(NUM_CHANNELS));
    assign legacy_hit = op_reg == OP_CC && num_reg == CC_DATA_MSB && stat.legacy_sel;

    always_comb
    begin
        primary_cmd = UPD_NONE;
        unique case (op_reg)
            OP_CC:
            begin
                priority if (num_reg == CC_MOD_WHEEL)
                    primary_cmd = UPD_MOD;
                else if (num_reg == CC_TIMBRE)
                    primary_cmd = UPD_TIMBRE;
                else if (num_reg == CC_RPN_MSB)
                    primary_cmd = UPD_RPN_HI;
                else if (num_reg == CC_RPN_LSB)
                    primary_cmd = UPD_RPN_LO;
                else if (num_reg == CC_DATA_MSB && stat.legacy_sel)
                    primary_cmd = UPD_NONE;
                else if (num_reg == CC_DATA_MSB && stat.bend_sel)
                    primary_cmd = UPD_SEMIS;
                else if (num_reg == CC_DATA_LSB && stat.bend_sel)
                    primary_cmd = UPD_CENTS;
                else
                    primary_cmd = UPD_NONE;
            end
            OP_PRESSURE: primary_cmd = UPD_PRESSURE;
            OP_WHEEL:    primary_cmd = UPD_NONE;
            OP_NOTE:     primary_cmd = UPD_NONE;
            default:     primary_cmd = UPD_NONE;
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            OP_CC:       member_cmd = (num_reg == CC_MOD_WHEEL) ? UPD_MOD : UPD_TIMBRE;
            OP_PRESSURE: member_cmd = UPD_PRESSURE;
            default:     member_cmd = UPD_NONE;
        endcase
    end

    always_comb
    begin
        unique case (op_reg)
            OP_CC:       op_kind = KIND_CC;
            OP_PRESSURE: op_kind = KIND_PRESSURE;
            OP_WHEEL:    op_kind = KIND_WHEEL;
            OP_NOTE:     op_kind = KIND_NOTE;
            default:     op_kind = KIND_NOTE;
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (event_valid)
                    state_next = ST_PRIMARY;
            end
            ST_PRIMARY:
            begin
                if (adv)
                begin
                    priority if (stat.range_upd)
                        state_next = ST_MAIN;
                    else if (fan_go)
                        state_next = ST_FAN;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_MAIN:
            begin
                if (adv)
                    state_next = fan_go ? ST_FAN : ST_IDLE;
            end
            ST_FAN:
            begin
                if (adv && fan_last)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        event_stall  = 1'b1;
        chan_req     = '{we: 1'b0, idx: slot(ch_reg), cmd: UPD_NONE, v7: v7_reg, val: val_reg};
        legacy       = '{we: 1'b0, mgr: ch_reg, count: val_reg};
        emit         = 1'b0;
        item = '{
            kind:                  op_kind,
            out_channel:           ch_reg,
            out_number:            (op_reg == OP_CC || op_reg == OP_NOTE) ? num_reg : 7'd0,
            out_value:             val_reg,
            mod_wheel_valid:       snap.mod_valid,
            mod_wheel_level:       snap.mod_level,
            pressure_level:        snap.pressure,
            timbre_level:          snap.timbre,
            bend_range_valid:      snap.range_valid,
            bend_range_hundredths: snap.range,
            last:                  1'b0
        };
        unique case (state_reg)
            ST_IDLE:
            begin
                event_stall = 1'b0;
            end
            ST_PRIMARY:
            begin
                chan_req.cmd = primary_cmd;
                chan_req.we  = adv;
                legacy.we    = adv && legacy_hit;
                emit         = adv;
                if (stat.range_upd)
                begin
                    item.kind      = KIND_BEND;
                    item.out_value = snap.range;
                end
                else
                begin
                    item.last = !fan_go;
                end
            end
            ST_MAIN:
            begin
                emit      = adv;
                item.last = !fan_go;
            end
            ST_FAN:
            begin
                chan_req.idx     = slot(m_reg);
                chan_req.cmd     = member_cmd;
                chan_req.we      = adv;
                emit             = adv;
                item.out_channel = m_reg;
                item.last        = fan_last;
            end
            default: ;
        endcase
    end

    always_comb
    begin
        op_next  = op_reg;
        ch_next  = ch_reg;
        num_next = num_reg;
        val_next = val_reg;
        v7_next  = v7_reg;
        if (accept)
        begin
            op_next  = event_item.op;
            ch_next  = clamp16(event_item.channel);
            num_next = event_item.number;
            val_next = event_item.value;
            v7_next  = (event_item.value > 14'(LEVEL_MAX)) ? LEVEL_MAX
                                                           : event_item.value[6:0];
        end
        m_next = m_reg;
        if (state_reg != ST_FAN && state_next == ST_FAN)
            m_next = zone.first;
        else if (state_reg == ST_FAN && adv)
            m_next = 5'(m_reg + 5'd1);
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_next       = item;
            out_valid_next = 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            m_reg         <= 5'd1;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            m_reg         <= m_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg  <= OP_CC;
            ch_reg  <= 5'd1;
            num_reg <= 7'd0;
            val_reg <= 14'd0;
            v7_reg  <= 7'd0;
            out_reg <= '0;
        end
        else
        begin
            op_reg  <= op_next;
            ch_reg  <= ch_next;
            num_reg <= num_next;
            val_reg <= val_next;
            v7_reg  <= v7_next;
            out_reg <= out_next;
        end
    end

    assign result_valid = out_valid_reg;
    assign result_item  = out_reg;

    `MMCR_ASSERT(a_accept_starts, accept |=> state_reg == ST_PRIMARY, "accept did not start work")
    `MMCR_ASSERT(a_stall_freezes, (out_valid_reg && result_stall && state_reg != ST_IDLE) |=> $stable(state_reg), "sequencer moved under stall")
    `MMCR_ASSERT_ALWAYS(a_bend_not_last, (out_valid_reg && out_reg.kind == KIND_BEND) |-> !out_reg.last, "bend update marked last")
    `MMCR_ASSERT(a_member_in_zone, state_reg == ST_FAN |-> (m_reg >= zone.first && m_reg <= zone.last), "member outside zone")

endmodule

@@ hdl/midi_mpe_controller_router_unit.sv @@
// top level of the mpe controller router
//
//  channel  | handshake            | payload
//  ---------+----------------------+-----------------------------
//  event    | event_valid/stall    | event_item (op, channel, ...)
//  result   | result_valid/stall   | result_item (kind, ..., last)
//  cfg      | cfg_valid/ready      | cfg_index, cfg_data
//
// an event is registered while idle, then its results (1 to 16) leave one per
// cycle while not stalled, through the shared per-channel read-modify-write port;
// the next event is taken once the last result is in the output register
// reset clears all channel state and the zone at once, no clearing pass
// result stall freezes the sequencer; event_stall is high while an event is in work
module midi_mpe_controller_router_unit
    import mmcr_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         event_valid,
    output logic         event_stall,
    input  event_item_t  event_item,
    output logic         result_valid,
    input  logic         result_stall,
    output result_item_t result_item,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [4:0]   cfg_data
);

    zone_t       zone;
    legacy_req_t legacy;
    chan_req_t   chan_req;
    snap_t       snap;
    chan_stat_t  stat;

    assign cfg_ready = 1'b1;

    mmcr_zone u_zone (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .legacy    (legacy),
        .zone      (zone)
    );

    mmcr_chan_unit u_chan (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (chan_req),
        .snap  (snap),
        .stat  (stat)
    );

    mmcr_seq u_seq (
        .clk          (clk),
        .rst_n        (rst_n),
        .event_valid  (event_valid),
        .event_stall  (event_stall),
        .event_item   (event_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item),
        .zone         (zone),
        .legacy       (legacy),
        .chan_req     (chan_req),
        .snap         (snap),
        .stat         (stat)
    );

endmodule
